// ===== rtl/pixel_point_operation_unit_defines.svh =====
// Assertion helpers for the pixel point-operation unit.
// Both expect clk and rst_n in scope.
`ifndef PIXEL_POINT_OPERATION_UNIT_DEFINES_SVH
`define PIXEL_POINT_OPERATION_UNIT_DEFINES_SVH

// Same-cycle implication
`define PPOU_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("pixel_point_operation_unit: same-cycle check failed");

// Next-cycle implication
`define PPOU_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("pixel_point_operation_unit: next-cycle check failed");

`endif

// ===== rtl/ppou_pkg.sv =====
package ppou_pkg;

  // Widest channel depth the unit handles
  localparam int CHANNEL_BITS = 8;
  // Pipeline depth: two front stages, three lane stages, one merge stage
  localparam int NSTAGE = 6;
  localparam int NLANE  = 3;

  // Operation codes
  localparam logic [2:0] MODE_REQUANT      = 3'd0;
  localparam logic [2:0] MODE_GRAY_AVG     = 3'd1;
  localparam logic [2:0] MODE_GRAY_LUMA    = 3'd2;
  localparam logic [2:0] MODE_NEGATIVE     = 3'd3;
  localparam logic [2:0] MODE_PLANE_MASK   = 3'd4;
  localparam logic [2:0] MODE_SINGLE_PLANE = 3'd5;

  // Register indexes
  localparam logic [2:0] REG_OP_MODE        = 3'd0;
  localparam logic [2:0] REG_SOURCE_IS_RGB  = 3'd1;
  localparam logic [2:0] REG_CURRENT_LEVELS = 3'd2;
  localparam logic [2:0] REG_TARGET_LEVELS  = 3'd3;
  localparam logic [2:0] REG_PLANE_MASK     = 3'd4;
  localparam logic [2:0] REG_PLANE_INDEX    = 3'd5;

  // Luma weights, unsigned Q0.16
  localparam logic [15:0] LUMA_WR = 16'd13938;
  localparam logic [15:0] LUMA_WG = 16'd46869;
  localparam logic [15:0] LUMA_WB = 16'd4730;

  // Divide by three: multiply by ceil(2^17/3), shift by 17
  localparam logic [15:0] AVG_RECIP = 16'd43691;

  typedef struct packed {
    logic [7:0] chan_red;
    logic [7:0] chan_green;
    logic [7:0] chan_blue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       out_is_gray;
    logic       refused;
  } pix_out_t;

  // Decoded configuration shared by all stages
  typedef struct packed {
    logic [2:0]  mode;
    logic        rgb;
    logic [3:0]  cur;
    logic [3:0]  tgt;
    logic [7:0]  dm;     // mask of current depth
    logic [7:0]  tm;     // mask of target depth
    logic [16:0] recip;  // floor(2^16 / dm)
    logic        up;     // target deeper than current
    logic [7:0]  mask;
    logic [2:0]  idx;
  } ctrl_t;

  function automatic logic [3:0] clamp_levels(input logic [3:0] lv);
    logic [3:0] r;
    if (lv == 4'd0) r = 4'd1;
    else if (lv > 4'(CHANNEL_BITS)) r = 4'(CHANNEL_BITS);
    else r = lv;
    return r;
  endfunction

  function automatic logic [7:0] depth_mask(input logic [3:0] lv);
    logic [8:0] m;
    m = (9'd1 << lv) - 9'd1;
    return m[7:0];
  endfunction

  // Reciprocal of 2^c-1 for the scale-up divide
  function automatic logic [16:0] depth_recip(input logic [3:0] lv);
    logic [16:0] r;
    case (lv)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd21845;
      4'd3:    r = 17'd9362;
      4'd4:    r = 17'd4369;
      4'd5:    r = 17'd2114;
      4'd6:    r = 17'd1040;
      4'd7:    r = 17'd516;
      4'd8:    r = 17'd257;
      default: r = 17'd257;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ppou_front.sv =====
// Front end: channel masking and gray conversion, two stages.
module ppou_front import ppou_pkg::*; (
  input  logic       clk,
  input  logic [1:0] en,
  input  ctrl_t      ctrl,
  input  pix_in_t    in_data,
  output pix_in_t    raw,
  output logic [7:0] ln_val [NLANE]
);

  logic [7:0]  mr, mg, mb;
  pix_in_t     raw1_r, raw2_r;
  logic [23:0] pr_r, pg_r, pb_r;
  logic [9:0]  sum_r;
  logic [23:0] luma_sum;
  logic [7:0]  luma_r;
  logic [25:0] avg_r;
  logic [7:0]  y;
  logic        gconv;

  assign mr = in_data.chan_red   & ctrl.dm;
  assign mg = in_data.chan_green & ctrl.dm;
  assign mb = in_data.chan_blue  & ctrl.dm;

  // Stage 1: weighted products and plain sum
  always_ff @(posedge clk) begin
    if (en[0]) begin
      raw1_r <= in_data;
      pr_r   <= 24'(mr) * 24'(LUMA_WR);
      pg_r   <= 24'(mg) * 24'(LUMA_WG);
      pb_r   <= 24'(mb) * 24'(LUMA_WB);
      sum_r  <= 10'(mr) + 10'(mg) + 10'(mb);
    end
  end

  // Weights sum to 65537, so the total stays below 2^24
  assign luma_sum = pr_r + pg_r + pb_r;

  // Stage 2: luma truncated, average by reciprocal
  always_ff @(posedge clk) begin
    if (en[1]) begin
      raw2_r <= raw1_r;
      luma_r <= luma_sum[23:16];
      avg_r  <= 26'(sum_r) * 26'(AVG_RECIP);
    end
  end

  assign y     = (ctrl.mode == MODE_GRAY_AVG) ? avg_r[24:17] : luma_r;
  assign gconv = ((ctrl.mode == MODE_GRAY_AVG) || (ctrl.mode == MODE_GRAY_LUMA)) && ctrl.rgb;

  assign raw       = raw2_r;
  assign ln_val[0] = (gconv ? y : raw2_r.chan_red) & ctrl.dm;
  assign ln_val[1] = raw2_r.chan_green & ctrl.dm;
  assign ln_val[2] = raw2_r.chan_blue  & ctrl.dm;

endmodule

// ===== rtl/ppou_lane.sv =====
// One channel's point operation, three stages. Scale-up divides by
// 2^c-1 through a reciprocal multiply and a one-step correction.
module ppou_lane import ppou_pkg::*; (
  input  logic       clk,
  input  logic [2:0] en,
  input  ctrl_t      ctrl,
  input  logic [7:0] val,
  input  logic [7:0] raw,
  output logic [7:0] res,
  output logic [7:0] raw_out
);

  logic [7:0]  v1_r, raw1_r, v2_r, raw2_r, res3_r, raw3_r;
  logic [15:0] x1_r, x2_r;
  logic [32:0] p2_r;
  logic [7:0]  q_est, q_up, q_down, op_res;
  logic [16:0] rem;
  logic [3:0]  shamt;

  // Stage 1: v * (2^t - 1)
  always_ff @(posedge clk) begin
    if (en[0]) begin
      v1_r   <= val;
      raw1_r <= raw;
      x1_r   <= 16'(val) * 16'(ctrl.tm);
    end
  end

  // Stage 2: multiply by reciprocal of 2^c - 1
  always_ff @(posedge clk) begin
    if (en[1]) begin
      v2_r   <= v1_r;
      raw2_r <= raw1_r;
      x2_r   <= x1_r;
      p2_r   <= 33'(x1_r) * 33'(ctrl.recip);
    end
  end

  // Quotient estimate is exact or one low; remainder decides
  assign q_est  = p2_r[23:16];
  assign rem    = 17'(x2_r) + 17'(q_est) - (17'(q_est) << ctrl.cur);
  assign q_up   = (rem >= 17'(ctrl.dm)) ? q_est + 8'd1 : q_est;
  assign shamt  = ctrl.cur - ctrl.tgt;
  assign q_down = v2_r >> shamt;

  always_comb begin
    case (ctrl.mode)
      MODE_REQUANT,
      MODE_GRAY_AVG,
      MODE_GRAY_LUMA:    op_res = ctrl.up ? q_up : q_down;
      MODE_NEGATIVE:     op_res = ~v2_r & ctrl.dm;
      MODE_PLANE_MASK:   op_res = v2_r & ctrl.mask;
      MODE_SINGLE_PLANE: op_res = {7'd0, v2_r[ctrl.idx]};
      default:           op_res = v2_r;
    endcase
  end

  // Stage 3: operation result
  always_ff @(posedge clk) begin
    if (en[2]) begin
      res3_r <= op_res;
      raw3_r <= raw2_r;
    end
  end

  assign res     = res3_r;
  assign raw_out = raw3_r;

endmodule

// ===== rtl/ppou_merge.sv =====
// Merge: builds the result pixel from the lanes and the gray/refused flags.
module ppou_merge import ppou_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  ctrl_t      ctrl,
  input  logic [7:0] res [NLANE],
  input  logic [7:0] raw [NLANE],
  output pix_out_t   out_data
);

  pix_out_t o_nxt, out_r;
  logic     gconv, unused;

  assign gconv  = (ctrl.mode == MODE_GRAY_AVG) || (ctrl.mode == MODE_GRAY_LUMA);
  assign unused = ctrl.mode > MODE_SINGLE_PLANE;

  always_comb begin
    o_nxt = '0;
    if (gconv) begin
      o_nxt.out_is_gray = 1'b1;
      if (!ctrl.rgb) begin
        o_nxt.refused = 1'b1;
        o_nxt.out_red = raw[0];
      end else begin
        o_nxt.out_red = res[0];
      end
    end else if (unused) begin
      o_nxt.out_red = raw[0];
      if (ctrl.rgb) begin
        o_nxt.out_green = raw[1];
        o_nxt.out_blue  = raw[2];
      end else begin
        o_nxt.out_is_gray = 1'b1;
      end
    end else if (ctrl.rgb) begin
      o_nxt.out_red   = res[0];
      o_nxt.out_green = res[1];
      o_nxt.out_blue  = res[2];
    end else begin
      o_nxt.out_is_gray = 1'b1;
      o_nxt.out_red     = res[0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= o_nxt;
    end
  end

  assign out_data = out_r;

endmodule

// ===== rtl/pixel_point_operation_unit.sv =====
// Pixel point-operation unit: takes and returns one pixel per clock while the
// output is not stalled, through its pipeline stages (two front stages for gray
// conversion, three stages in each of the three channel lanes for the
// scale-up multiply, reciprocal multiply and correction, one output stage).
// Each stage holds its beat until the next stage frees up, so the input
// stalls only when all six stages are full and the output is stalled.
// Configuration writes are taken in any cycle and must only be made while
// no beat is in flight.
`include "pixel_point_operation_unit_defines.svh"

module pixel_point_operation_unit import ppou_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  pix_in_t    in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output pix_out_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [2:0]        op_mode_r;
  logic              source_is_rgb_r;
  logic [3:0]        current_levels_r;
  logic [3:0]        target_levels_r;
  logic [7:0]        plane_mask_r;
  logic [2:0]        plane_index_r;
  ctrl_t             ctrl;
  logic [NSTAGE-1:0] vld_r;
  logic [NSTAGE-1:0] en;
  pix_in_t           f_raw;
  logic [7:0]        ln_val [NLANE];
  logic [7:0]        ln_raw [NLANE];
  logic [7:0]        ln_res [NLANE];
  logic [7:0]        ln_raw_out [NLANE];
  logic              out_gb_zero;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r        <= MODE_REQUANT;
      source_is_rgb_r  <= 1'b1;
      current_levels_r <= 4'd8;
      target_levels_r  <= 4'd8;
      plane_mask_r     <= 8'hff;
      plane_index_r    <= 3'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OP_MODE:        op_mode_r        <= cfg_data[2:0];
        REG_SOURCE_IS_RGB:  source_is_rgb_r  <= cfg_data[0];
        REG_CURRENT_LEVELS: current_levels_r <= cfg_data[3:0];
        REG_TARGET_LEVELS:  target_levels_r  <= cfg_data[3:0];
        REG_PLANE_MASK:     plane_mask_r     <= cfg_data;
        REG_PLANE_INDEX:    plane_index_r    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Decoded control
  always_comb begin
    ctrl       = '0;
    ctrl.mode  = op_mode_r;
    ctrl.rgb   = source_is_rgb_r;
    ctrl.cur   = clamp_levels(current_levels_r);
    ctrl.tgt   = clamp_levels(target_levels_r);
    ctrl.dm    = depth_mask(ctrl.cur);
    ctrl.tm    = depth_mask(ctrl.tgt);
    ctrl.recip = depth_recip(ctrl.cur);
    ctrl.up    = ctrl.tgt > ctrl.cur;
    ctrl.mask  = plane_mask_r;
    ctrl.idx   = plane_index_r;
  end

  // Stage enables: a stage loads when empty or when the next one moves
  always_comb begin
    en[NSTAGE-1] = !vld_r[NSTAGE-1] || !out_stall;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[NSTAGE-1];

  ppou_front u_front (
    .clk     (clk),
    .en      (en[1:0]),
    .ctrl    (ctrl),
    .in_data (in_data),
    .raw     (f_raw),
    .ln_val  (ln_val)
  );

  assign ln_raw[0] = f_raw.chan_red;
  assign ln_raw[1] = f_raw.chan_green;
  assign ln_raw[2] = f_raw.chan_blue;

  // Channel lanes
  for (genvar i = 0; i < NLANE; i++) begin : g_lane
    ppou_lane u_lane (
      .clk     (clk),
      .en      (en[4:2]),
      .ctrl    (ctrl),
      .val     (ln_val[i]),
      .raw     (ln_raw[i]),
      .res     (ln_res[i]),
      .raw_out (ln_raw_out[i])
    );
  end

  ppou_merge u_merge (
    .clk      (clk),
    .en       (en[5]),
    .ctrl     (ctrl),
    .res      (ln_res),
    .raw      (ln_raw_out),
    .out_data (out_data)
  );

  // Checks
  assign out_gb_zero = (out_data.out_green == 8'd0) && (out_data.out_blue == 8'd0);

  `PPOU_ASSERT_NOW(a_stall_only_full, in_stall, (&vld_r) && out_stall)
  `PPOU_ASSERT_NEXT(a_accept_fills_first, in_valid && !in_stall, vld_r[0])
  `PPOU_ASSERT_NOW(a_gray_clears_gb, out_valid && out_data.out_is_gray, out_gb_zero)
  `PPOU_ASSERT_NOW(a_refused_is_gray, out_valid && out_data.refused, out_data.out_is_gray)

endmodule
